// ----- design/ucer_pkg.sv -----
// Package with shared types, codes and the descriptor table of the endpoint-0 responder.
`timescale 1ns / 1ps
package ucer_pkg;

  localparam int unsigned STORE_BYTES = 50;
  localparam int unsigned DEV_BYTES = 18;
  localparam int unsigned CFG_BYTES = 32;
  localparam int unsigned CHUNK_BYTES = 32;

  localparam logic [1:0] KIND_SETUP = 2'd0;
  localparam logic [1:0] KIND_IN = 2'd1;
  localparam logic [1:0] KIND_OUT = 2'd2;
  localparam logic [1:0] KIND_RESET = 2'd3;

  localparam logic [1:0] HS_NAK = 2'd0;
  localparam logic [1:0] HS_ACK = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  localparam logic [2:0] REQ_IDLE = 3'd0;
  localparam logic [2:0] REQ_GET_DESC = 3'd1;
  localparam logic [2:0] REQ_SET_ADDR = 3'd2;
  localparam logic [2:0] REQ_OTHER = 3'd3;
  localparam logic [2:0] REQ_STALLED = 3'd4;

  localparam logic [7:0] CODE_SET_ADDRESS = 8'd5;
  localparam logic [7:0] CODE_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] CODE_GET_CONFIG = 8'd8;
  localparam logic [7:0] CODE_SET_CONFIG = 8'd9;
  localparam logic [7:0] CODE_GET_MAX_LUN = 8'hFE;
  localparam logic [7:0] CODE_BULK_RESET = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
    logic emit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_done;
  } stat_t;

  function automatic logic [7:0] desc_byte(input logic [5:0] a);
    logic [7:0] b;
    begin
      case (a)
        6'd0: b = 8'h12; 6'd1: b = 8'h01; 6'd2: b = 8'h10; 6'd3: b = 8'h01;
        6'd4: b = 8'h00; 6'd5: b = 8'h00; 6'd6: b = 8'h00; 6'd7: b = 8'h20;
        6'd8: b = 8'h1A; 6'd9: b = 8'h86; 6'd10: b = 8'hFE; 6'd11: b = 8'h10;
        6'd12: b = 8'h01; 6'd13: b = 8'h00; 6'd14: b = 8'h00; 6'd15: b = 8'h00;
        6'd16: b = 8'h00; 6'd17: b = 8'h01;
        6'd18: b = 8'h09; 6'd19: b = 8'h02; 6'd20: b = 8'h20; 6'd21: b = 8'h00;
        6'd22: b = 8'h01; 6'd23: b = 8'h01; 6'd24: b = 8'h00; 6'd25: b = 8'hA0;
        6'd26: b = 8'h32;
        6'd27: b = 8'h09; 6'd28: b = 8'h04; 6'd29: b = 8'h00; 6'd30: b = 8'h00;
        6'd31: b = 8'h02; 6'd32: b = 8'h08; 6'd33: b = 8'h06; 6'd34: b = 8'h50;
        6'd35: b = 8'h00;
        6'd36: b = 8'h07; 6'd37: b = 8'h05; 6'd38: b = 8'h82; 6'd39: b = 8'h02;
        6'd40: b = 8'h20; 6'd41: b = 8'h00; 6'd42: b = 8'h00;
        6'd43: b = 8'h07; 6'd44: b = 8'h05; 6'd45: b = 8'h02; 6'd46: b = 8'h02;
        6'd47: b = 8'h20; 6'd48: b = 8'h00; 6'd49: b = 8'h00;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

// ----- design/ucer_ctrl.sv -----
// Controller state machine of the endpoint-0 responder.
`timescale 1ns / 1ps
module ucer_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_fire,
  input  ucer_pkg::stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output ucer_pkg::ctrl_t ctrl
);

  ucer_pkg::state_t state;
  ucer_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucer_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    ctrl = '0;
    case (state)
      ucer_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctrl.capture = 1'b1;
          state_next = ucer_pkg::ST_DECIDE;
        end
      end
      ucer_pkg::ST_DECIDE: begin
        ctrl.apply = 1'b1;
        state_next = ucer_pkg::ST_EMIT;
      end
      ucer_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          ctrl.emit = 1'b1;
          if (stat.emit_done) begin
            state_next = ucer_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = ucer_pkg::ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("Input and output open together.");
  a_capture_then_decide: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ucer_pkg::ST_DECIDE)
    else $error("Accepted item was not decoded.");
  a_emit_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && stat.emit_done) |=> in_ready)
    else $error("Controller did not return to idle.");
`endif

endmodule

// ----- design/ucer_datapath.sv -----
// Datapath of the endpoint-0 responder: request decode, state registers and byte output.
`timescale 1ns / 1ps
module ucer_datapath (
  input  logic            clk,
  input  logic            rst,
  input  ucer_pkg::ctrl_t ctrl,
  input  logic [55:0]     in_data,
  output ucer_pkg::stat_t stat,
  output logic [31:0]     out_data,
  output logic            out_last
);

  logic [55:0] item;
  logic [2:0] active_request;
  logic [7:0] remaining_bytes;
  logic [5:0] descriptor_offset;
  logic [6:0] pending_address;
  logic [6:0] address_reg;
  logic [7:0] configuration_reg;
  logic [1:0] pending_report_bits;
  logic [1:0] reported_bits;
  logic toggle_bit;
  logic [1:0] tx_hs;
  logic rx_hs;
  logic [5:0] count;
  logic [5:0] idx;
  logic single;
  logic [7:0] single_byte;
  logic single_valid;
  logic pulse;

  logic [1:0] kind;
  logic len_ok;
  logic [7:0] rt, code, vlo, vhi, ilo, len;
  logic [7:0] rem_chunk;
  logic [7:0] byte_now;
  logic [6:0] addr_sum;

  assign kind = item[1:0];
  assign len_ok = item[2];
  assign rt = item[10:3];
  assign code = item[18:11];
  assign vlo = item[26:19];
  assign vhi = item[34:27];
  assign ilo = item[42:35];
  assign len = item[50:43];

  assign rem_chunk = (remaining_bytes > 8'(ucer_pkg::CHUNK_BYTES)) ?
                     8'(ucer_pkg::CHUNK_BYTES) : remaining_bytes;
  assign addr_sum = {1'b0, descriptor_offset} + {1'b0, idx};
  assign byte_now = single ? single_byte :
                    ((addr_sum < 7'(ucer_pkg::STORE_BYTES)) ?
                     ucer_pkg::desc_byte(addr_sum[5:0]) : 8'h00);

  assign stat.emit_done = (idx == count);
  assign out_last = stat.emit_done;
  assign out_data = {2'd0, pulse, (reported_bits == 2'b11), configuration_reg, address_reg,
                     single ? single_valid : 1'b1, byte_now, toggle_bit, rx_hs, tx_hs};

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item <= in_data;
    end
    if (rst) begin
      active_request <= ucer_pkg::REQ_IDLE;
      remaining_bytes <= '0;
      descriptor_offset <= '0;
      pending_address <= '0;
      address_reg <= '0;
      configuration_reg <= '0;
      pending_report_bits <= '0;
      reported_bits <= '0;
      toggle_bit <= 1'b0;
      tx_hs <= ucer_pkg::HS_NAK;
      rx_hs <= 1'b0;
      count <= '0;
      idx <= '0;
      single <= 1'b1;
      single_byte <= '0;
      single_valid <= 1'b0;
      pulse <= 1'b0;
    end else if (ctrl.apply) begin
      idx <= '0;
      count <= '0;
      single <= 1'b1;
      single_byte <= '0;
      single_valid <= 1'b0;
      pulse <= 1'b0;
      case (kind)
        ucer_pkg::KIND_SETUP: begin
          tx_hs <= ucer_pkg::HS_ACK;
          rx_hs <= 1'b0;
          toggle_bit <= 1'b1;
          if (!len_ok) begin
            active_request <= ucer_pkg::REQ_STALLED;
            tx_hs <= ucer_pkg::HS_STALL;
            rx_hs <= 1'b1;
          end else if (rt[6:5] == 2'b01 && rt[4:0] == 5'd1 && ilo == 8'd0) begin
            pending_report_bits <= '0;
            if (code == ucer_pkg::CODE_GET_MAX_LUN && rt[7] && len == 8'd1) begin
              active_request <= ucer_pkg::REQ_OTHER;
              single_valid <= 1'b1;
            end else if (code == ucer_pkg::CODE_BULK_RESET && !rt[7] && len == 8'd0) begin
              active_request <= ucer_pkg::REQ_OTHER;
              pulse <= 1'b1;
            end else begin
              active_request <= ucer_pkg::REQ_STALLED;
              tx_hs <= ucer_pkg::HS_STALL;
              rx_hs <= 1'b1;
            end
          end else if (rt[6:5] != 2'b00) begin
            active_request <= ucer_pkg::REQ_STALLED;
            tx_hs <= ucer_pkg::HS_STALL;
            rx_hs <= 1'b1;
          end else begin
            pending_report_bits <= '0;
            if (code == ucer_pkg::CODE_GET_DESCRIPTOR && (vhi == 8'd1 || vhi == 8'd2)) begin
              logic [7:0] dlen;
              logic [7:0] rem;
              logic [7:0] ch;
              dlen = (vhi == 8'd1) ? 8'(ucer_pkg::DEV_BYTES) : 8'(ucer_pkg::CFG_BYTES);
              rem = (len > dlen) ? dlen : len;
              ch = (rem > 8'(ucer_pkg::CHUNK_BYTES)) ? 8'(ucer_pkg::CHUNK_BYTES) : rem;
              if (len >= dlen) begin
                pending_report_bits <= (vhi == 8'd1) ? 2'b01 : 2'b10;
              end
              active_request <= ucer_pkg::REQ_GET_DESC;
              descriptor_offset <= (vhi == 8'd1) ? 6'd0 : 6'(ucer_pkg::DEV_BYTES);
              remaining_bytes <= rem - ch;
              if (ch != 8'd0) begin
                single <= 1'b0;
                count <= 6'(ch - 8'd1);
              end
            end else if (code == ucer_pkg::CODE_SET_ADDRESS) begin
              pending_address <= vlo[6:0];
              active_request <= ucer_pkg::REQ_SET_ADDR;
            end else if (code == ucer_pkg::CODE_GET_CONFIG) begin
              active_request <= ucer_pkg::REQ_OTHER;
              if (len != 8'd0) begin
                single_valid <= 1'b1;
                single_byte <= configuration_reg;
              end
            end else if (code == ucer_pkg::CODE_SET_CONFIG) begin
              configuration_reg <= vlo;
              active_request <= ucer_pkg::REQ_OTHER;
            end else begin
              active_request <= ucer_pkg::REQ_STALLED;
              tx_hs <= ucer_pkg::HS_STALL;
              rx_hs <= 1'b1;
            end
          end
        end
        ucer_pkg::KIND_IN: begin
          if (active_request == ucer_pkg::REQ_GET_DESC) begin
            toggle_bit <= ~toggle_bit;
            remaining_bytes <= remaining_bytes - rem_chunk;
            if (rem_chunk != 8'd0) begin
              single <= 1'b0;
              count <= 6'(rem_chunk - 8'd1);
            end
          end else begin
            if (active_request == ucer_pkg::REQ_SET_ADDR) begin
              address_reg <= pending_address;
            end
            tx_hs <= ucer_pkg::HS_NAK;
            rx_hs <= 1'b0;
            toggle_bit <= 1'b0;
          end
        end
        ucer_pkg::KIND_OUT: begin
          if (active_request == ucer_pkg::REQ_GET_DESC && pending_report_bits != 2'b00) begin
            reported_bits <= reported_bits | pending_report_bits;
            pending_report_bits <= '0;
          end
          tx_hs <= ucer_pkg::HS_NAK;
          rx_hs <= 1'b0;
          toggle_bit <= 1'b0;
        end
        default: begin
          address_reg <= '0;
          configuration_reg <= '0;
          reported_bits <= '0;
          pending_report_bits <= '0;
          tx_hs <= ucer_pkg::HS_NAK;
          rx_hs <= 1'b0;
          toggle_bit <= 1'b0;
        end
      endcase
    end else if (ctrl.emit) begin
      if (stat.emit_done) begin
        if (!single) begin
          descriptor_offset <= descriptor_offset + idx + 6'd1;
        end
      end else begin
        idx <= idx + 6'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count < 6'(ucer_pkg::CHUNK_BYTES))
    else $error("Chunk longer than one packet.");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst) idx <= count)
    else $error("Byte index ran past the chunk.");
  a_single_one: assert property (@(posedge clk) disable iff (rst) single |-> count == 6'd0)
    else $error("Single result with a byte count.");
`endif

endmodule

// ----- design/usb_control_endpoint_responder.sv -----
// Top level of the endpoint-0 control responder.
//   channel | direction | fields
//   s_axis  | in        | tdata: kind, setup_length_ok, setup_type, request_code,
//           |           |        value_low, value_high, index_low, length_low
//   m_axis  | out       | tdata: response and status fields; tlast: last
// An item is accepted in the idle state, decoded in the decide state and then emitted
// at one result per cycle while the output is ready: up to 32 descriptor bytes, counted
// by the byte counter of the output sequencer.
// One item is in work at a time; a stalled output holds the current result.
// Synchronous active-high reset returns to idle with address, configuration and report
// state cleared.
`timescale 1ns / 1ps
module usb_control_endpoint_responder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0], setup_length_ok[2], setup_type[10:3], request_code[18:11],
  // value_low[26:19], value_high[34:27], index_low[42:35], length_low[50:43]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_response[1:0], rx_response[2], tx_data_toggle[3], data_byte[11:4],
  // data_valid[12], device_address[19:13], config_value[27:20], enumerated[28],
  // bulk_reset_pulse[29]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  ucer_pkg::ctrl_t ctrl;
  ucer_pkg::stat_t stat;

  ucer_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .stat(stat),
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid),
    .ctrl(ctrl)
  );

  ucer_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .in_data(s_axis_tdata),
    .stat(stat),
    .out_data(m_axis_tdata),
    .out_last(m_axis_tlast)
  );

endmodule

// ----- verif/usb_control_endpoint_responder_tb.sv -----
// Self-checking testbench of the endpoint-0 control responder with a scoreboard and predictor.
`timescale 1ns / 1ps
module usb_control_endpoint_responder_tb;

  typedef struct {
    logic [1:0] tx_response;
    logic       rx_response;
    logic       tx_data_toggle;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    logic [6:0] device_address;
    logic [7:0] config_value;
    logic       enumerated;
    logic       bulk_reset_pulse;
  } ep0_result_t;

  localparam logic [7:0] DESC_ROM [0:49] = '{
    8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h20, 8'h1A, 8'h86,
    8'hFE, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
    8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hA0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
    8'h07, 8'h05, 8'h82, 8'h02, 8'h20, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, 8'h20, 8'h00, 8'h00
  };

  class ep0_scoreboard;
    ep0_result_t expected_q[$];
    int          errors = 0;
    logic [2:0]  req = ucer_pkg::REQ_IDLE;
    logic [7:0]  remaining = 0;
    int          offset = 0;
    logic [6:0]  pend_addr = 0;
    logic [6:0]  addr = 0;
    logic [7:0]  cfg = 0;
    logic [1:0]  pend_bits = 0;
    logic [1:0]  rep_bits = 0;
    logic        toggle = 0;
    logic [1:0]  tx_hs = ucer_pkg::HS_NAK;
    logic        rx_hs = 0;

    function void push(logic [7:0] b, logic v, logic pulse);
      ep0_result_t r;
      r.tx_response = tx_hs;
      r.rx_response = rx_hs;
      r.tx_data_toggle = toggle;
      r.data_byte = b;
      r.data_valid = v;
      r.last = 0;
      r.device_address = addr;
      r.config_value = cfg;
      r.enumerated = (rep_bits == 2'b11);
      r.bulk_reset_pulse = pulse;
      expected_q.push_back(r);
    endfunction

    function void go_idle();
      tx_hs = ucer_pkg::HS_NAK;
      rx_hs = 0;
      toggle = 0;
    endfunction

    function void go_ack();
      tx_hs = ucer_pkg::HS_ACK;
      rx_hs = 0;
      toggle = 1;
    endfunction

    function void load_chunk();
      int n;
      n = (remaining > ucer_pkg::CHUNK_BYTES) ? ucer_pkg::CHUNK_BYTES : remaining;
      if (n == 0) push(0, 0, 0);
      for (int i = 0; i < n; i++)
        push((offset + i < ucer_pkg::STORE_BYTES) ? DESC_ROM[offset + i] : 8'h00, 1, 0);
      remaining = remaining - n;
      offset = offset + n;
    endfunction

    function void decode_setup(logic [55:0] d);
      logic [7:0] rt, code, vlo, vhi, ilo, len;
      logic       stall;
      logic       pulse;
      int         dlen;
      rt = d[10:3];
      code = d[18:11];
      vlo = d[26:19];
      vhi = d[34:27];
      ilo = d[42:35];
      len = d[50:43];
      stall = 0;
      pulse = 0;
      if (!d[2]) begin
        stall = 1;
      end else if (rt[6:5] == 2'b01 && rt[4:0] == 5'd1 && ilo == 0) begin
        pend_bits = 0;
        if (code == ucer_pkg::CODE_GET_MAX_LUN && rt[7] && len == 1) begin
          req = ucer_pkg::REQ_OTHER;
          go_ack();
          push(8'h00, 1, 0);
          return;
        end else if (code == ucer_pkg::CODE_BULK_RESET && !rt[7] && len == 0) begin
          req = ucer_pkg::REQ_OTHER;
          pulse = 1;
        end else begin
          stall = 1;
        end
      end else if (rt[6:5] != 0) begin
        stall = 1;
      end else begin
        pend_bits = 0;
        if (code == ucer_pkg::CODE_GET_DESCRIPTOR) begin
          if (vhi == 1 || vhi == 2) begin
            dlen = (vhi == 1) ? ucer_pkg::DEV_BYTES : ucer_pkg::CFG_BYTES;
            if (len >= dlen) pend_bits = vhi[1:0];
            remaining = (len > dlen) ? dlen : len;
            offset = (vhi == 1) ? 0 : ucer_pkg::DEV_BYTES;
            req = ucer_pkg::REQ_GET_DESC;
            go_ack();
            load_chunk();
            return;
          end
          stall = 1;
        end else if (code == ucer_pkg::CODE_SET_ADDRESS) begin
          pend_addr = vlo[6:0];
          req = ucer_pkg::REQ_SET_ADDR;
        end else if (code == ucer_pkg::CODE_GET_CONFIG) begin
          req = ucer_pkg::REQ_OTHER;
          go_ack();
          if (len >= 1) push(cfg, 1, 0);
          else push(0, 0, 0);
          return;
        end else if (code == ucer_pkg::CODE_SET_CONFIG) begin
          cfg = vlo;
          req = ucer_pkg::REQ_OTHER;
        end else begin
          stall = 1;
        end
      end
      if (stall) begin
        req = ucer_pkg::REQ_STALLED;
        tx_hs = ucer_pkg::HS_STALL;
        rx_hs = 1;
        toggle = 1;
      end else begin
        go_ack();
      end
      push(0, 0, pulse);
    endfunction

    function void note_event(logic [55:0] d);
      case (d[1:0])
        ucer_pkg::KIND_SETUP: decode_setup(d);
        ucer_pkg::KIND_IN: begin
          if (req == ucer_pkg::REQ_GET_DESC) begin
            toggle = ~toggle;
            load_chunk();
          end else begin
            if (req == ucer_pkg::REQ_SET_ADDR) addr = pend_addr;
            go_idle();
            push(0, 0, 0);
          end
        end
        ucer_pkg::KIND_OUT: begin
          if (req == ucer_pkg::REQ_GET_DESC && pend_bits != 0) begin
            rep_bits = rep_bits | pend_bits;
            pend_bits = 0;
          end
          go_idle();
          push(0, 0, 0);
        end
        default: begin
          addr = 0;
          cfg = 0;
          rep_bits = 0;
          pend_bits = 0;
          go_idle();
          push(0, 0, 0);
        end
      endcase
      expected_q[expected_q.size() - 1].last = 1;
    endfunction

    function void cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] d, logic tl);
      ep0_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no expected item: tdata %h", d);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("tx_response", e.tx_response, d[1:0]);
      cmp("rx_response", e.rx_response, d[2]);
      cmp("tx_data_toggle", e.tx_data_toggle, d[3]);
      cmp("data_byte", e.data_byte, d[11:4]);
      cmp("data_valid", e.data_valid, d[12]);
      cmp("last", e.last, tl);
      cmp("device_address", e.device_address, d[19:13]);
      cmp("config_value", e.config_value, d[27:20]);
      cmp("enumerated", e.enumerated, d[28]);
      cmp("bulk_reset_pulse", e.bulk_reset_pulse, d[29]);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  ep0_scoreboard sb = new();
  int  hold = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 0;

  usb_control_endpoint_responder i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast);
        hold = no_idle ? 0 : $urandom_range(0, 3);
        if (hold != 0) m_axis_tready <= 0;
      end else if (!m_axis_tready) begin
        if (hold > 0) hold--;
        if (hold == 0) m_axis_tready <= 1;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= 3000) begin
        $display("usb_control_endpoint_responder_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [55:0] ep0_event(logic [1:0] kind, logic ok, logic [7:0] rt,
      logic [7:0] code, logic [7:0] vlo, logic [7:0] vhi, logic [7:0] ilo, logic [7:0] len);
    return {5'd0, len, ilo, vhi, vlo, code, rt, ok, kind};
  endfunction

  task automatic send_event(logic [55:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_event(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [7:0] len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
    case ($urandom_range(0, 7))
      0, 1: send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80,
                                 ucer_pkg::CODE_GET_DESCRIPTOR, $urandom,
                                 $urandom_range(1, 2), $urandom, len));
      2: send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h00, ucer_pkg::CODE_SET_ADDRESS,
                              $urandom, $urandom, $urandom, 0));
      3: send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h00, ucer_pkg::CODE_SET_CONFIG,
                              $urandom, $urandom, $urandom, 0));
      4: send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_CONFIG,
                              0, 0, 0, $urandom_range(0, 1)));
      5: send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'hA1, ucer_pkg::CODE_GET_MAX_LUN,
                              0, 0, 0, 1));
      6: send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h21, ucer_pkg::CODE_BULK_RESET,
                              0, 0, 0, 0));
      default: send_event(ep0_event(ucer_pkg::KIND_SETUP, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom));
    endcase
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk);
    rst <= 0;
    m_axis_tready <= 1;

    send_event(ep0_event(ucer_pkg::KIND_IN, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 1, 0, 8'hFF));
    send_event(ep0_event(ucer_pkg::KIND_IN, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_OUT, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 2, 0, 8'hFF));
    send_event(ep0_event(ucer_pkg::KIND_IN, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_OUT, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 2, 0, 9));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 3, 0, 8'hFF));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 1, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_IN, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h00, ucer_pkg::CODE_SET_ADDRESS,
                         8'hFF, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_IN, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h00, ucer_pkg::CODE_SET_CONFIG,
                         8'hFF, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_CONFIG,
                         0, 0, 0, 1));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h80, ucer_pkg::CODE_GET_CONFIG,
                         0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'hA1, ucer_pkg::CODE_GET_MAX_LUN,
                         0, 0, 0, 1));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'hA1, ucer_pkg::CODE_GET_MAX_LUN,
                         0, 0, 0, 2));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h21, ucer_pkg::CODE_BULK_RESET,
                         0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'hA1, ucer_pkg::CODE_BULK_RESET,
                         0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 0, 8'h80, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 1, 0, 8'hFF));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h40, ucer_pkg::CODE_GET_DESCRIPTOR,
                         0, 1, 0, 8'hFF));
    send_event(ep0_event(ucer_pkg::KIND_SETUP, 1, 8'h00, 8'h01, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_IN, 0, 0, 0, 0, 0, 0, 0));
    send_event(ep0_event(ucer_pkg::KIND_RESET, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                         8'hFF));

    // Hold off new items until every outstanding result has come back.
    drain();

    sent = 0;
    while (sent < 95) begin
      if (sent == 40) no_idle = 1;
      if (sent == 60) no_idle = 0;
      if ($urandom_range(0, 9) < 7) begin
        random_setup();
        sent++;
        repeat ($urandom_range(0, 3)) begin
          send_event(ep0_event(ucer_pkg::KIND_IN, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_event(ep0_event(ucer_pkg::KIND_OUT, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom));
          sent++;
        end
      end else begin
        send_event({5'd0, 51'($urandom) | (51'($urandom) << 32)});
        sent++;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("usb_control_endpoint_responder_tb: done, clean");
    else
      $display("usb_control_endpoint_responder_tb: done, errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/ucer_pkg.sv
design/ucer_ctrl.sv
design/ucer_datapath.sv
design/usb_control_endpoint_responder.sv
verif/usb_control_endpoint_responder_tb.sv
